>>> rtl/core/opf_pkg.sv
package opf_pkg;

  localparam logic [1:0] KIND_PACKET  = 2'd0;
  localparam logic [1:0] KIND_ERROR   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_HEADER    = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED = 2'd2;

  localparam logic [7:0] LEN_TWO_MIN  = 8'd192;
  localparam logic [7:0] LEN_TWO_MAX  = 8'd223;
  localparam logic [7:0] LEN_FIVE     = 8'd255;
  localparam logic [1:0] OLD_LEN_INDET = 2'd3;
  localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } opf_in_t;

  typedef struct packed {
    logic [1:0]  report_kind;
    logic [5:0]  packet_type;
    logic        new_format;
    logic [2:0]  header_length;
    logic [31:0] body_length;
    logic [1:0]  error_code;
    logic [31:0] packet_count;
    logic        last_result;
  } opf_out_t;

  // up to two result words produced by one input word
  typedef struct packed {
    logic     v0;
    logic     v1;
    opf_out_t r0;
    opf_out_t r1;
  } opf_push_t;

endpackage

>>> rtl/core/opf_step.sv
module opf_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  opf_pkg::opf_in_t   item,
  output opf_pkg::opf_push_t push
);

  typedef enum logic [2:0] {
    PH_TAG, PH_NEWFIRST, PH_LENGTH, PH_BODY, PH_INDET, PH_NEWTWO
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [5:0]  type_r, type_nxt;
  logic        newf_r, newf_nxt;
  logic [2:0]  left_r, left_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  hdr_r, hdr_nxt;
  logic [31:0] body_r, body_nxt;
  logic        stop_r, stop_nxt;
  logic [31:0] count_r, count_nxt;

  opf_pkg::opf_out_t main_res, eob_res, sum_res, first_res;
  logic              main_v, eob_v, first_v;
  logic [7:0]        b;
  logic [31:0]       len;
  logic              hdone;

  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    newf_nxt  = newf_r;
    left_nxt  = left_r;
    acc_nxt   = acc_r;
    hdr_nxt   = hdr_r;
    body_nxt  = body_r;
    stop_nxt  = stop_r;
    count_nxt = count_r;
    main_v    = 1'b0;
    eob_v     = 1'b0;
    main_res  = '0;
    eob_res   = '0;
    sum_res   = '0;
    b         = item.data_byte;
    len       = 32'd0;
    hdone     = 1'b0;

    if (!stop_r) begin
      unique case (phase_r)
        PH_TAG: begin
          hdr_nxt = 3'd1;
          if (!b[7]) begin
            type_nxt = 6'd0;
            newf_nxt = 1'b0;
            main_v   = 1'b1;
            main_res.report_kind   = opf_pkg::KIND_ERROR;
            main_res.header_length = 3'd1;
            main_res.error_code    = opf_pkg::ERR_HEADER;
            stop_nxt = 1'b1;
          end else if (b[6]) begin
            type_nxt  = b[5:0];
            newf_nxt  = 1'b1;
            phase_nxt = PH_NEWFIRST;
          end else begin
            type_nxt = {2'b00, b[5:2]};
            newf_nxt = 1'b0;
            acc_nxt  = 32'd0;
            if (b[1:0] == opf_pkg::OLD_LEN_INDET) begin
              phase_nxt = PH_INDET;
            end else begin
              left_nxt  = (b[1:0] == 2'd0) ? 3'd1 : (b[1:0] == 2'd1) ? 3'd2 : 3'd4;
              phase_nxt = PH_LENGTH;
            end
          end
        end
        PH_NEWFIRST: begin
          hdr_nxt = 3'd2;
          if (b < opf_pkg::LEN_TWO_MIN) begin
            hdone = 1'b1;
            len   = {24'd0, b};
          end else if (b <= opf_pkg::LEN_TWO_MAX) begin
            acc_nxt   = {19'd0, b[4:0], 8'd0} + 32'd192;
            phase_nxt = PH_NEWTWO;
          end else if (b == opf_pkg::LEN_FIVE) begin
            acc_nxt   = 32'd0;
            left_nxt  = 3'd4;
            phase_nxt = PH_LENGTH;
          end else begin
            main_v = 1'b1;
            main_res.report_kind   = opf_pkg::KIND_ERROR;
            main_res.packet_type   = type_r;
            main_res.new_format    = newf_r;
            main_res.header_length = 3'd2;
            main_res.error_code    = opf_pkg::ERR_HEADER;
            stop_nxt = 1'b1;
          end
        end
        PH_NEWTWO: begin
          hdr_nxt = hdr_r + 3'd1;
          hdone   = 1'b1;
          len     = acc_r + {24'd0, b};
        end
        PH_LENGTH: begin
          hdr_nxt = hdr_r + 3'd1;
          acc_nxt = {acc_r[23:0], b};
          if (left_r != 3'd0) left_nxt = left_r - 3'd1;
          if (left_nxt == 3'd0) begin
            hdone = 1'b1;
            len   = acc_nxt;
          end
        end
        PH_BODY: begin
          if (body_r != 32'd0) body_nxt = body_r - 32'd1;
          if (body_nxt == 32'd0) begin
            if (count_r != opf_pkg::COUNT_MAX) count_nxt = count_r + 32'd1;
            main_v = 1'b1;
            main_res.report_kind   = opf_pkg::KIND_PACKET;
            main_res.packet_type   = type_r;
            main_res.new_format    = newf_r;
            main_res.header_length = hdr_r;
            main_res.body_length   = acc_r;
            phase_nxt = PH_TAG;
          end
        end
        PH_INDET: begin
          if (acc_r != opf_pkg::COUNT_MAX) acc_nxt = acc_r + 32'd1;
        end
        default: phase_nxt = PH_TAG;
      endcase

      if (hdone) begin
        acc_nxt = len;
        if (len == 32'd0) begin
          if (count_r != opf_pkg::COUNT_MAX) count_nxt = count_r + 32'd1;
          main_v = 1'b1;
          main_res.report_kind   = opf_pkg::KIND_PACKET;
          main_res.packet_type   = type_nxt;
          main_res.new_format    = newf_nxt;
          main_res.header_length = hdr_nxt;
          phase_nxt = PH_TAG;
        end else begin
          body_nxt  = len;
          phase_nxt = PH_BODY;
        end
      end
      main_res.packet_count = count_nxt;
    end

    if (item.end_of_buffer) begin
      if (!stop_nxt) begin
        eob_res.packet_type   = type_nxt;
        eob_res.new_format    = newf_nxt;
        eob_res.header_length = hdr_nxt;
        if (phase_nxt == PH_NEWFIRST || phase_nxt == PH_NEWTWO ||
            phase_nxt == PH_LENGTH) begin
          eob_v = 1'b1;
          eob_res.report_kind = opf_pkg::KIND_ERROR;
          eob_res.error_code  = opf_pkg::ERR_HEADER;
        end else if (phase_nxt == PH_BODY) begin
          eob_v = 1'b1;
          eob_res.report_kind = opf_pkg::KIND_ERROR;
          eob_res.body_length = acc_nxt;
          eob_res.error_code  = opf_pkg::ERR_TRUNCATED;
        end else if (phase_nxt == PH_INDET) begin
          if (count_nxt != opf_pkg::COUNT_MAX) count_nxt = count_nxt + 32'd1;
          eob_v = 1'b1;
          eob_res.report_kind = opf_pkg::KIND_PACKET;
          eob_res.body_length = acc_nxt;
        end
      end
      eob_res.packet_count  = count_nxt;
      sum_res.report_kind   = opf_pkg::KIND_SUMMARY;
      sum_res.packet_count  = count_nxt;
      sum_res.last_result   = 1'b1;
      phase_nxt = PH_TAG;
      type_nxt  = 6'd0;
      newf_nxt  = 1'b0;
      left_nxt  = 3'd0;
      acc_nxt   = 32'd0;
      hdr_nxt   = 3'd0;
      body_nxt  = 32'd0;
      stop_nxt  = 1'b0;
      count_nxt = 32'd0;
    end

    first_v   = main_v | eob_v;
    first_res = main_v ? main_res : eob_res;
    first_res.last_result = !item.end_of_buffer;

    push.v0 = go & (first_v | item.end_of_buffer);
    push.v1 = go & first_v & item.end_of_buffer;
    push.r0 = first_v ? first_res : sum_res;
    push.r1 = sum_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      type_r  <= '0;
      newf_r  <= 1'b0;
      left_r  <= '0;
      acc_r   <= '0;
      hdr_r   <= '0;
      body_r  <= '0;
      stop_r  <= 1'b0;
      count_r <= '0;
    end else if (go) begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      newf_r  <= newf_nxt;
      left_r  <= left_nxt;
      acc_r   <= acc_nxt;
      hdr_r   <= hdr_nxt;
      body_r  <= body_nxt;
      stop_r  <= stop_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

>>> rtl/core/opf_outq.sv
module opf_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  opf_pkg::opf_push_t push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output opf_pkg::opf_out_t  out_data
);

  opf_pkg::opf_out_t mem_r [4];
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [2:0] npush;

  assign pop       = out_valid & out_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = mem_r[rd_r];
  assign room      = (cnt_r <= 3'd2);
  assign npush     = {2'b00, push.v0} + {2'b00, push.v1};

  always_comb begin
    wr_nxt  = wr_r + npush[1:0];
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + npush - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push.v0) mem_r[wr_r] <= push.r0;
    if (push.v1) mem_r[wr_r + 2'd1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/openpgp_packet_framer.sv
// OpenPGP packet framer.
// in_ channel: one buffer byte per word (data_byte, end_of_buffer on the
// last byte). out_ channel: report words (packet completed, error stop,
// end-of-buffer summary with the packet count); a byte causes 0, 1 or 2.
// Both channels are valid/ready; a word moves when valid and ready are high.
// A byte is held in an input register and parsed, once the queue has room,
// by one pass of combinational logic; its reports land in a 4-word result
// queue, which registers each report before it is shown on out_.
// Throughput: one byte per cycle while the queue has room for two words;
// a byte that ends a buffer gives two words and thus drains at one per cycle.
// When out_ready is low, the queue fills and in_ready drops once fewer than
// two queue slots would be left; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears the parser to expect a tag byte with
// a zero packet count and empties the input register and the queue.
// After an end-of-buffer summary the parser returns to that same state.
module openpgp_packet_framer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  opf_pkg::opf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output opf_pkg::opf_out_t out_data
);

  logic               hold_v_r, hold_v_nxt;
  opf_pkg::opf_in_t   hold_r;
  logic               room;
  logic               go;
  opf_pkg::opf_push_t push;

  assign go         = hold_v_r & room;
  assign in_ready   = !hold_v_r | go;
  assign hold_v_nxt = (in_valid & in_ready) | (hold_v_r & !go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid & in_ready) hold_r <= in_data;
  end

  opf_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (hold_r),
    .push  (push)
  );

  opf_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import opf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TARGET_WORDS = 1050;

  // {end_of_buffer, data_byte}
  localparam logic [8:0] DIRECTED [26] = '{
    9'h0FF, 9'h000, 9'h084, 9'h001, 9'h07E, 9'h0C3, 9'h0FF, 9'h000, 9'h000, 9'h000,
    9'h000, 9'h187,
    9'h100,
    9'h0C1, 9'h0E0, 9'h012, 9'h1FE,
    9'h08A, 9'h000, 9'h100,
    9'h0DF, 9'h0C0, 9'h100,
    9'h08F, 9'h001, 9'h1FF
  };

  typedef enum logic [2:0] {
    ST_TAG, ST_NEW_FIRST, ST_LEN_OCTETS, ST_BODY, ST_INDET, ST_NEW_SECOND
  } parse_state_t;

  typedef struct {
    opf_in_t word;
    bit      drain;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  opf_in_t   in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  opf_out_t  out_data;

  stim_t       pending_words[$];
  stim_t       next_word;
  opf_out_t    expected_reports[$];
  logic [7:0]  buf_bytes[$];
  int          words_queued;
  int          words_taken;
  int          mismatches;
  int          cycle_count;

  // parser mirror
  parse_state_t pstate;
  logic [5:0]   hdr_type;
  logic         hdr_new;
  logic [2:0]   len_left;
  logic [31:0]  len_acc;
  logic [2:0]   hdr_seen;
  logic [31:0]  body_left;
  logic         halted;
  logic [31:0]  pkt_count;

  openpgp_packet_framer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function void clear_parser();
    pstate    = ST_TAG;
    hdr_type  = '0;
    hdr_new   = 1'b0;
    len_left  = '0;
    len_acc   = '0;
    hdr_seen  = '0;
    body_left = '0;
    halted    = 1'b0;
    pkt_count = '0;
  endfunction

  function void push_report(logic [1:0] kind, logic [5:0] ptype, logic nf, logic [2:0] hl,
                            logic [31:0] bl, logic [1:0] ec);
    opf_out_t r;
    r.report_kind   = kind;
    r.packet_type   = ptype;
    r.new_format    = nf;
    r.header_length = hl;
    r.body_length   = bl;
    r.error_code    = ec;
    r.packet_count  = pkt_count;
    r.last_result   = 1'b0;
    expected_reports.push_back(r);
  endfunction

  function void close_packet(logic [31:0] bl);
    if (pkt_count != COUNT_MAX) pkt_count = pkt_count + 32'd1;
    push_report(KIND_PACKET, hdr_type, hdr_new, hdr_seen, bl, ERR_NONE);
    pstate = ST_TAG;
  endfunction

  function void header_complete(logic [31:0] len);
    len_acc = len;
    if (len == 0) begin
      close_packet('0);
    end else begin
      body_left = len;
      pstate = ST_BODY;
    end
  endfunction

  function void halt_parse(logic [31:0] bl, logic [1:0] ec);
    push_report(KIND_ERROR, hdr_type, hdr_new, hdr_seen, bl, ec);
    halted = 1'b1;
  endfunction

  function void frame_byte(opf_in_t w);
    logic [7:0] b;
    int         first_new;
    b = w.data_byte;
    first_new = expected_reports.size();
    if (!halted) begin
      case (pstate)
        ST_TAG: begin
          hdr_seen = 3'd1;
          if (!b[7]) begin
            hdr_type = '0;
            hdr_new = 1'b0;
            halt_parse('0, ERR_HEADER);
          end else if (b[6]) begin
            hdr_type = b[5:0];
            hdr_new = 1'b1;
            pstate = ST_NEW_FIRST;
          end else begin
            hdr_type = {2'b00, b[5:2]};
            hdr_new = 1'b0;
            len_acc = '0;
            if (b[1:0] == OLD_LEN_INDET) begin
              pstate = ST_INDET;
            end else begin
              len_left = (b[1:0] == 2'd0) ? 3'd1 : (b[1:0] == 2'd1) ? 3'd2 : 3'd4;
              pstate = ST_LEN_OCTETS;
            end
          end
        end
        ST_NEW_FIRST: begin
          hdr_seen = 3'd2;
          if (b < LEN_TWO_MIN) begin
            header_complete(32'(b));
          end else if (b <= LEN_TWO_MAX) begin
            len_acc = ((32'(b) - 32'(LEN_TWO_MIN)) << 8) + 32'(LEN_TWO_MIN);
            pstate = ST_NEW_SECOND;
          end else if (b == LEN_FIVE) begin
            len_acc = '0;
            len_left = 3'd4;
            pstate = ST_LEN_OCTETS;
          end else begin
            halt_parse('0, ERR_HEADER);
          end
        end
        ST_NEW_SECOND: begin
          hdr_seen = hdr_seen + 3'd1;
          header_complete(len_acc + 32'(b));
        end
        ST_LEN_OCTETS: begin
          hdr_seen = hdr_seen + 3'd1;
          len_acc = {len_acc[23:0], b};
          if (len_left != 0) len_left = len_left - 3'd1;
          if (len_left == 0) header_complete(len_acc);
        end
        ST_BODY: begin
          if (body_left != 0) body_left = body_left - 32'd1;
          if (body_left == 0) close_packet(len_acc);
        end
        ST_INDET: begin
          if (len_acc != COUNT_MAX) len_acc = len_acc + 32'd1;
        end
        default: pstate = ST_TAG;
      endcase
    end
    if (w.end_of_buffer) begin
      if (!halted) begin
        if (pstate == ST_NEW_FIRST || pstate == ST_NEW_SECOND || pstate == ST_LEN_OCTETS) begin
          halt_parse('0, ERR_HEADER);
        end else if (pstate == ST_BODY) begin
          halt_parse(len_acc, ERR_TRUNCATED);
        end else if (pstate == ST_INDET) begin
          close_packet(len_acc);
        end
      end
      push_report(KIND_SUMMARY, '0, 1'b0, '0, '0, ERR_NONE);
      clear_parser();
    end
    if (expected_reports.size() > first_new) expected_reports[$].last_result = 1'b1;
  endfunction

  function void queue_word(logic [7:0] b, bit eob);
    stim_t s;
    s.word.data_byte = b;
    s.word.end_of_buffer = eob;
    s.drain = 1'b0;
    pending_words.push_back(s);
    words_queued++;
  endfunction

  function void queue_drain();
    stim_t s;
    s.word = '0;
    s.drain = 1'b1;
    pending_words.push_back(s);
  endfunction

  function void add_body(int unsigned n);
    repeat (n) buf_bytes.push_back(8'($urandom));
  endfunction

  function void add_length(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) buf_bytes.push_back(v[8*i +: 8]);
  endfunction

  // long declared bodies are cut short by the end of the buffer
  function bit add_declared_body(logic [31:0] dlen);
    if (dlen > 8) begin
      add_body($urandom_range(0, 4));
      return 1'b1;
    end
    add_body(dlen);
    return 1'b0;
  endfunction

  // returns 1 when nothing may follow in this buffer
  function bit add_packet();
    int unsigned form;
    int unsigned blen;
    int unsigned extra;
    logic [31:0] dlen;
    logic [3:0]  old_type;
    bit          open_end;
    open_end = 1'b0;
    old_type = 4'($urandom);
    blen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 191) : $urandom_range(0, 6);
    dlen = ($urandom_range(0, 1) == 0) ? 32'(blen) :
           ($urandom_range(0, 3) == 0) ? COUNT_MAX : 32'($urandom);
    form = $urandom_range(0, 9);
    case (form)
      0, 1, 2: begin
        buf_bytes.push_back({2'b11, 6'($urandom)});
        buf_bytes.push_back(8'(blen));
        add_body(blen);
      end
      3: begin
        buf_bytes.push_back({2'b11, 6'($urandom)});
        if ($urandom_range(0, 5) == 0) begin
          extra = $urandom_range(0, 15);
          buf_bytes.push_back(LEN_TWO_MIN);
          buf_bytes.push_back(8'(extra));
          add_body(32'(LEN_TWO_MIN) + extra);
        end else begin
          buf_bytes.push_back(8'($urandom_range(LEN_TWO_MIN, LEN_TWO_MAX)));
          buf_bytes.push_back(8'($urandom));
          add_body($urandom_range(0, 4));
          open_end = 1'b1;
        end
      end
      4: begin
        buf_bytes.push_back({2'b11, 6'($urandom)});
        buf_bytes.push_back(LEN_FIVE);
        add_length(dlen, 4);
        open_end = add_declared_body(dlen);
      end
      5: begin
        buf_bytes.push_back({2'b10, old_type, 2'b00});
        add_length(blen, 1);
        add_body(blen);
      end
      6: begin
        buf_bytes.push_back({2'b10, old_type, 2'b01});
        add_length(blen, 2);
        add_body(blen);
      end
      7: begin
        buf_bytes.push_back({2'b10, old_type, 2'b10});
        add_length(dlen, 4);
        open_end = add_declared_body(dlen);
      end
      8: begin
        buf_bytes.push_back({2'b10, old_type, OLD_LEN_INDET});
        add_body($urandom_range(0, 6));
        open_end = 1'b1;
      end
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          buf_bytes.push_back({1'b0, 7'($urandom)});
        end else begin
          buf_bytes.push_back({2'b11, 6'($urandom)});
          buf_bytes.push_back(8'($urandom_range(32'(LEN_TWO_MAX) + 1, 32'(LEN_FIVE) - 1)));
        end
        add_body($urandom_range(0, 3));
        open_end = 1'b1;
      end
    endcase
    return open_end;
  endfunction

  function void gen_buffer();
    int unsigned npk;
    int unsigned cut;
    bit          open_end;
    buf_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      add_body($urandom_range(1, 6));
    end else begin
      npk = $urandom_range(1, 5);
      open_end = 1'b0;
      while (npk > 0 && !open_end) begin
        open_end = add_packet();
        npk--;
      end
      if (!open_end && buf_bytes.size() > 1 && $urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, buf_bytes.size() - 1);
        buf_bytes = buf_bytes[0:cut-1];
      end
    end
    foreach (buf_bytes[i]) queue_word(buf_bytes[i], i == buf_bytes.size() - 1);
  endfunction

  function bit may_idle();
    return (words_taken < 400 || words_taken >= 700) && $urandom_range(0, 99) < 7;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      clear_parser();
    end else begin
      if (in_valid && in_ready) begin
        frame_byte(in_data);
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && pending_words[0].drain) begin
          in_valid <= 1'b0;
          if (expected_reports.size() == 0) void'(pending_words.pop_front());
        end else if (pending_words.size() == 0 || may_idle()) begin
          in_valid <= 1'b0;
        end else begin
          next_word = pending_words.pop_front();
          in_valid <= 1'b1;
          in_data <= next_word.word;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    opf_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t ns: report expected none, got %h", $time, out_data);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          if (out_data !== want) begin
            $display("%0t ns: report expected %p, got %p", $time, want, out_data);
            mismatches++;
          end
        end
      end
      out_ready <= !may_idle();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    bit mid_drain_done;
    mid_drain_done = 1'b0;
    foreach (DIRECTED[i]) queue_word(DIRECTED[i][7:0], DIRECTED[i][8]);
    queue_drain();
    while (words_queued < TARGET_WORDS) begin
      gen_buffer();
      if (!mid_drain_done && words_queued >= 600) begin
        queue_drain();
        mid_drain_done = 1'b1;
      end
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
